>>> src/sti_pkg.sv
// sti_pkg: shared types and constants for the sorted table block
// operation and status codes, request/response words, cell control group
// no dependencies
package sti_pkg;

   localparam int DEFAULT_CAPACITY = 32;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_ABSENT = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE   = 1'b0,
      S_SEARCH = 1'b1
   } state_type;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [4:0]  found_index;
      logic [5:0]  entry_count;
   } rsp_type;

   // strobes from the controller to every cell
   typedef struct packed {
      logic ins_en;   // shift up and drop the key in
      logic rem_en;   // close the gap at the removal position
      logic flag_en;  // capture compare flags against the incoming key
   } cell_ctl_type;

endpackage

>>> src/sti_cell.sv
// sti_cell: one table slot, holding a single signed entry
// shifts with its neighbours on add and remove, keeps registered compare flags
// depends on sti_pkg
module sti_cell #(
   parameter int CELL_IDX = 0,
   parameter int IDX_W    = 5,
   parameter int CNT_W    = 6
) (
   input  logic                  clock,
   input  sti_pkg::cell_ctl_type cell_ctl,
   input  logic signed [31:0]    key,
   input  logic [CNT_W-1:0]      count,
   input  logic [IDX_W-1:0]      rem_pos,
   input  logic signed [31:0]    prev_entry,
   input  logic                  prev_gt,
   input  logic signed [31:0]    next_entry,
   output logic signed [31:0]    entry,
   output logic                  gt,
   output logic                  lt_flag,
   output logic                  eq_flag
);
   import sti_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(CELL_IDX);
   localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(CELL_IDX + 1);

   logic signed [31:0] entry_ff, entry_in;
   logic               lt_ff, eq_ff;
   logic               valid;
   logic               at_end;
   logic               rem_here;

   assign valid    = MY_IDX < count;
   assign at_end   = MY_IDX == count;
   assign gt       = valid && (entry_ff > key);
   assign rem_here = (MY_IDX >= CNT_W'(rem_pos)) && (MY_NEXT < count);

   always_comb begin
      entry_in = entry_ff;
      if (cell_ctl.ins_en) begin
         if (prev_gt) begin
            entry_in = prev_entry;
         end else if (gt || at_end) begin
            entry_in = key;
         end
      end else if (cell_ctl.rem_en && rem_here) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (cell_ctl.flag_en) begin
         lt_ff <= entry_ff < key;
         eq_ff <= entry_ff == key;
      end
   end

   assign entry   = entry_ff;
   assign lt_flag = lt_ff;
   assign eq_flag = eq_ff;

endmodule

>>> src/sti_ctrl.sv
// sti_ctrl: operation sequencer for the sorted table
// binary search over the cell flags, entry count, response register
// depends on sti_pkg
module sti_ctrl #(
   parameter int CAPACITY = 32,
   parameter int IDX_W    = 5,
   parameter int CNT_W    = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  sti_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sti_pkg::rsp_type       rsp_data,
   input  logic [CAPACITY-1:0]    lt_flags,
   input  logic [CAPACITY-1:0]    eq_flags,
   output sti_pkg::cell_ctl_type  cell_ctl,
   output logic [IDX_W-1:0]       rem_pos,
   output logic [CNT_W-1:0]       count
);
   import sti_pkg::*;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hix_ff, hix_in;     // one past the upper bound
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             rsp_free;
   logic [CNT_W:0]   mid_sum;
   logic [IDX_W-1:0] mid;
   logic             issue;
   status_type       issue_status;
   logic [IDX_W-1:0] issue_index;
   logic [CNT_W-1:0] issue_count;
   logic [IDX_W+4:0] index_wide;
   logic [CNT_W+5:0] count_wide;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && rsp_free;
   assign accept    = req_valid && req_ready;

   // floor midpoint of lo and hi, with hi kept as hix - 1
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hix_ff} - (CNT_W+1)'(1);
   assign mid     = mid_sum[IDX_W:1];

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hix_in       = hix_ff;
      cell_ctl     = '0;
      rem_pos      = mid;
      issue        = 1'b0;
      issue_status = ST_OK;
      issue_index  = '0;
      issue_count  = count_ff;
      cell_ctl.flag_en = accept;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.operation)
                  OP_ADD: begin
                     issue = 1'b1;
                     if (count_ff == CAP_CNT) begin
                        issue_status = ST_FULL;
                     end else begin
                        cell_ctl.ins_en = 1'b1;
                        count_in        = count_ff + CNT_W'(1);
                        issue_count     = count_ff + CNT_W'(1);
                     end
                  end
                  OP_REMOVE, OP_SEARCH: begin
                     state_in = S_SEARCH;
                     op_in    = req_data.operation;
                     lo_in    = '0;
                     hix_in   = count_ff;
                  end
                  OP_NONE: begin
                     issue = 1'b1;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (hix_ff > lo_ff) begin
               if (eq_flags[mid]) begin
                  if (rsp_free) begin
                     issue    = 1'b1;
                     state_in = S_IDLE;
                     if (op_ff == OP_REMOVE) begin
                        cell_ctl.rem_en = 1'b1;
                        count_in        = count_ff - CNT_W'(1);
                        issue_count     = count_ff - CNT_W'(1);
                     end else begin
                        issue_index = mid;
                     end
                  end
               end else if (lt_flags[mid]) begin
                  lo_in = CNT_W'(mid) + CNT_W'(1);
               end else begin
                  hix_in = CNT_W'(mid);
               end
            end else if (rsp_free) begin
               issue        = 1'b1;
               issue_status = ST_ABSENT;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   // response fields are the low bits of index and count
   assign index_wide = (IDX_W+5)'(issue_index);
   assign count_wide = (CNT_W+6)'(issue_count);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (issue) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.status      = issue_status;
         rsp_data_in.found_index = index_wide[4:0];
         rsp_data_in.entry_count = count_wide[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      lo_ff       <= lo_in;
      hix_ff      <= hix_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign count     = count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count beyond capacity");

   a_search_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (lo_ff <= hix_ff && hix_ff <= count_ff))
      else $error("search bounds out of range");

   a_one_shift: assert property (@(posedge clock) disable iff (reset)
      !(cell_ctl.ins_en && cell_ctl.rem_en))
      else $error("add and remove shift together");

   a_add_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.operation == OP_ADD && count_ff != CAP_CNT)
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("add did not grow the table");
`endif

endmodule

>>> src/sorted_table_insert_search_remove.sv
// sorted_table_insert_search_remove: sorted signed table with add, remove, search
// a row of sti_cell slots driven by the sti_ctrl sequencer
// depends on sti_pkg, sti_cell, sti_ctrl
//
//   channel  ports              word                                  direction
//   req      req_valid/ready    req_data: operation, value            in
//   rsp      rsp_valid/ready    rsp_data: status, found_index, count  out
//
// add and the none code finish in the accept cycle: every cell compares in parallel
// and the row shifts up in the accept cycle, and the response is registered
// search and remove run a binary search, one probe a cycle on registered per-cell
// compare flags, the last one held while the response is stalled
// a miss ends on an empty range; remove shifts down on its last cycle
// reset clears the count and control only; the entry cells need no reset
// a stalled response holds the sequencer; one operation is in flight at a time
module sorted_table_insert_search_remove #(
   parameter int CAPACITY = sti_pkg::DEFAULT_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sti_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sti_pkg::rsp_type rsp_data
);
   import sti_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   cell_ctl_type        cell_ctl;
   logic [IDX_W-1:0]    rem_pos;
   logic [CNT_W-1:0]    count;
   logic signed [31:0]  entries [CAPACITY];
   logic [CAPACITY-1:0] gt_flags;
   logic [CAPACITY-1:0] lt_flags;
   logic [CAPACITY-1:0] eq_flags;

   sti_ctrl #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .lt_flags  (lt_flags),
      .eq_flags  (eq_flags),
      .cell_ctl  (cell_ctl),
      .rem_pos   (rem_pos),
      .count     (count)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      // end cells see a quiet neighbour
      logic signed [31:0] prev_entry, next_entry;
      logic               prev_gt;

      if (i == 0) begin : g_first
         assign prev_entry = '0;
         assign prev_gt    = 1'b0;
      end else begin : g_mid
         assign prev_entry = entries[i-1];
         assign prev_gt    = gt_flags[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_body
         assign next_entry = entries[i+1];
      end

      sti_cell #(
         .CELL_IDX (i),
         .IDX_W    (IDX_W),
         .CNT_W    (CNT_W)
      ) u_cell (
         .clock      (clock),
         .cell_ctl   (cell_ctl),
         .key        (req_data.value),
         .count      (count),
         .rem_pos    (rem_pos),
         .prev_entry (prev_entry),
         .prev_gt    (prev_gt),
         .next_entry (next_entry),
         .entry      (entries[i]),
         .gt         (gt_flags[i]),
         .lt_flag    (lt_flags[i]),
         .eq_flag    (eq_flags[i])
      );
   end

endmodule

>>> dv/testbench.sv
// testbench for sorted_table_insert_search_remove: directed and random add, remove and search
// words with random idling on both channels, checked against a shadow sorted table
// depends on sti_pkg and the block's rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sti_pkg::*;

   localparam int CAPACITY = DEFAULT_CAPACITY;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // shadow of the block's sorted table
   logic signed [31:0] shadow_keys [CAPACITY];
   int                 shadow_count;
   rsp_type            pending_words [$];

   int error_count;
   int hold_left;
   bit sender_stall;
   bit stall_enable;

   sorted_table_insert_search_remove #(
      .CAPACITY (CAPACITY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   // applies one accepted word to the shadow table and returns the word it owes
   function automatic rsp_type apply_to_shadow(req_type w);
      rsp_type            r;
      logic signed [31:0] key;
      int                 i, lo, hi, mid, pos;
      key = w.value;
      r.status = ST_OK;
      r.found_index = '0;
      case (w.operation)
         OP_ADD: begin
            if (shadow_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               i = shadow_count;
               // equal keys stay below the new one
               while (i > 0 && key < shadow_keys[i-1]) begin
                  shadow_keys[i] = shadow_keys[i-1];
                  i--;
               end
               shadow_keys[i] = key;
               shadow_count++;
            end
         end
         OP_REMOVE, OP_SEARCH: begin
            pos = -1;
            lo = 0;
            hi = shadow_count - 1;
            while (hi >= lo && pos < 0) begin
               mid = (lo + hi) / 2;
               if (shadow_keys[mid] == key) pos = mid;
               else if (shadow_keys[mid] < key) lo = mid + 1;
               else hi = mid - 1;
            end
            if (pos < 0) begin
               r.status = ST_ABSENT;
            end else if (w.operation == OP_SEARCH) begin
               r.found_index = pos[4:0];
            end else begin
               for (i = pos; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
               shadow_count--;
            end
         end
         default: ;
      endcase
      r.entry_count = shadow_count[5:0];
      return r;
   endfunction

   // request and response monitor: predict on accept, compare on delivery
   always @(posedge clock) begin : word_monitor
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) pending_words.push_back(apply_to_shadow(req_data));
         if (rsp_valid && rsp_ready) begin
            if (pending_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word: status %0d index %0d count %0d",
                                         rsp_data.status, rsp_data.found_index,
                                         rsp_data.entry_count));
            end else begin
               want = pending_words.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.found_index !== want.found_index)
                  report_mismatch($sformatf("found_index %0d, expected %0d",
                                            rsp_data.found_index, want.found_index));
               if (rsp_data.entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry_count %0d, expected %0d",
                                            rsp_data.entry_count, want.entry_count));
            end
         end
      end
   end

   // response side: random stalls after each word, plus long holds on request
   initial begin : rsp_receiver
      int stall_left;
      stall_left = $urandom_range(0, 3);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) stall_left = stall_enable ? $urandom_range(0, 3) : 0;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // valid is left high after acceptance so a back-to-back word never toggles it
   task automatic send_word(op_type op, logic [31:0] value);
      int gap;
      gap = sender_stall ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{operation: op, value: value};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value(int stored_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < stored_pct && shadow_count > 0)
         return shadow_keys[$urandom_range(0, shadow_count - 1)];
      r = $urandom_range(0, 9);
      if (r < 5) return 32'($urandom_range(0, 15)) - 32'd8;
      if (r < 7) begin
         case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      return $urandom();
   endfunction

   function automatic op_type pick_op(int add_pct, int remove_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < add_pct) return OP_ADD;
      if (r < add_pct + remove_pct) return OP_REMOVE;
      if (r < 96) return OP_SEARCH;
      return OP_NONE;
   endfunction

   task automatic test_empty_table();
      send_word(OP_SEARCH, 32'd0);
      send_word(OP_REMOVE, 32'h8000_0000);
      send_word(OP_NONE, 32'hffff_ffff);
   endtask

   task automatic test_extremes();
      send_word(OP_ADD, 32'h7fff_ffff);
      send_word(OP_ADD, 32'h8000_0000);
      send_word(OP_ADD, 32'h0000_0000);
      send_word(OP_ADD, 32'hffff_ffff);
      send_word(OP_SEARCH, 32'h8000_0000);
      send_word(OP_SEARCH, 32'h7fff_ffff);
      send_word(OP_SEARCH, 32'd7);
      send_word(OP_NONE, 32'h5555_aaaa);
   endtask

   task automatic test_duplicates();
      repeat (3) send_word(OP_ADD, 32'd5);
      send_word(OP_SEARCH, 32'd5);
      send_word(OP_REMOVE, 32'd5);
      send_word(OP_SEARCH, 32'd5);
      send_word(OP_REMOVE, 32'd6);
   endtask

   task automatic test_remove_all();
      send_word(OP_REMOVE, 32'h7fff_ffff);
      send_word(OP_REMOVE, 32'h8000_0000);
      send_word(OP_REMOVE, 32'h0000_0000);
      send_word(OP_REMOVE, 32'hffff_ffff);
      send_word(OP_REMOVE, 32'd5);
      send_word(OP_REMOVE, 32'd5);
   endtask

   // response side held off while adds keep coming: fills the table past full
   task automatic test_backpressure();
      hold_left = 400;
      repeat (40) send_word(OP_ADD, pick_value(30));
      send_word(OP_SEARCH, pick_value(80));
      wait_for_idle();
   endtask

   task automatic test_random(int total);
      int     done, phase_len, mode;
      op_type op;
      done = 0;
      while (done < total) begin
         mode = $urandom_range(0, 2);
         phase_len = $urandom_range(30, 80);
         sender_stall = ($urandom_range(0, 3) != 0);
         stall_enable = ($urandom_range(0, 3) != 0);
         repeat (phase_len) begin
            // grow, shrink or balanced phases so the count swings between empty and full
            case (mode)
               0:       op = pick_op(65, 10);
               1:       op = pick_op(10, 65);
               default: op = pick_op(35, 30);
            endcase
            send_word(op, pick_value(op == OP_ADD ? 20 : 70));
         end
         done += phase_len;
         if ($urandom_range(0, 4) == 0) wait_for_idle();
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      shadow_count = 0;
      error_count = 0;
      hold_left = 0;
      sender_stall = 1'b1;
      stall_enable = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_extremes();
      test_duplicates();
      test_remove_all();
      wait_for_idle();
      test_backpressure();
      test_random(2000);

      wait_for_idle();
      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
